@@ sv/scfp_pkg.sv @@
// ============================================================================
// scfp_pkg - shared types and constants for the sync/length/crc8 frame parser
// Holds the CRC-8 polynomial and the command/status structs of the serial CRC.
// ============================================================================
package scfp_pkg;

    // crc-8 polynomial, msb first, no reflection
    localparam logic [7:0] CRC_POLY = 8'hD5;

    // number of bit steps per byte in the serial crc
    localparam int unsigned CRC_STEPS = 8;

    typedef struct packed {
        logic       start;
        logic [7:0] seed;
    } crc_cmd_t;

    typedef struct packed {
        logic       busy;
        logic       last;
        logic [7:0] value;
    } crc_stat_t;

endpackage

@@ sv/scfp_ram.sv @@
// ============================================================================
// scfp_ram - generic simple dual-port ram
// One write port and one read port, read data registered.
// ============================================================================
module scfp_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 64
) (
    input  logic                                         clk,
    input  logic                                         we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0]   waddr,
    input  logic [WIDTH-1:0]                             wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0]   raddr,
    output logic [WIDTH-1:0]                             rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ sv/scfp_crc8.sv @@
// ============================================================================
// scfp_crc8 - bit-serial crc-8 unit
// Loads the seed (running crc xor byte) and shifts it through the lfsr
// one bit per cycle.
// ============================================================================
module scfp_crc8 (
    input  logic                 clk,
    input  logic                 rst_n,
    input  scfp_pkg::crc_cmd_t   cmd,
    output scfp_pkg::crc_stat_t  stat
);

    localparam int unsigned CNT_W = $clog2(scfp_pkg::CRC_STEPS + 1);

    logic [7:0]       crc_reg;
    logic [7:0]       crc_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;

    always_comb
    begin
        crc_next = crc_reg;
        cnt_next = cnt_reg;
        if (cmd.start)
        begin
            crc_next = cmd.seed;
            cnt_next = CNT_W'(scfp_pkg::CRC_STEPS);
        end
        else if (cnt_reg != '0)
        begin
            // one lfsr step, feedback on the msb
            crc_next = {crc_reg[6:0], 1'b0} ^ (crc_reg[7] ? scfp_pkg::CRC_POLY : 8'h00);
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            crc_reg <= crc_next;
            cnt_reg <= cnt_next;
        end
    end

    assign stat.busy  = (cnt_reg != '0);
    assign stat.last  = (cnt_reg == CNT_W'(1));
    assign stat.value = crc_reg;

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(scfp_pkg::CRC_STEPS))
        else $error("crc step count out of range");

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start |-> !stat.busy)
        else $error("crc started while still shifting");

endmodule

@@ sv/sync_length_crc8_frame_parser_core.sv @@
// input: a sync or crc byte is taken in the idle state; a length or payload byte is accepted,
//   then shifted through the bit-serial crc shift register
// no new input item is taken while the serial crc unit is still shifting
// read-out: after a good crc byte the payload is played out, each byte through a ram read,
//   then the output register, while the sink is ready
// reset: control state, sync value and running crc cleared; payload ram not cleared
// ============================================================================
// sync_length_crc8_frame_parser_core - sync/length/payload/crc-8 deframer
// Hunts for sync, collects payload into ram, checks crc-8 and plays out the
// payload of good frames; an empty good frame gives one zero item.
// ============================================================================
module sync_length_crc8_frame_parser_core #(
    parameter int unsigned MAX_PAYLOAD = 64
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  logic [7:0] cfg_wr_data,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] payload_byte
);

    localparam int unsigned AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam int unsigned CW = $clog2(MAX_PAYLOAD + 1);

    typedef enum logic [1:0] {
        PH_HUNT,
        PH_LEN,
        PH_DATA,
        PH_CHECK
    } phase_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CRC,
        S_RD,
        S_OUT
    } state_t;

    state_t              state_reg, state_next;
    phase_t              phase_reg, phase_next;
    logic [7:0]          sync_reg, sync_next;
    logic [CW-1:0]       len_reg, len_next;
    logic [CW-1:0]       fill_reg, fill_next;
    logic [CW-1:0]       rd_idx_reg, rd_idx_next;
    logic                empty_reg, empty_next;
    logic                out_valid_reg, out_valid_next;
    logic [7:0]          out_data_reg, out_data_next;

    scfp_pkg::crc_cmd_t  crc_cmd;
    scfp_pkg::crc_stat_t crc_stat;

    logic                ram_we;
    logic [7:0]          ram_rdata;
    logic                accept;
    logic                slot_free;
    logic                len_bad;
    logic                is_sync;
    logic [CW-1:0]       fill_inc;
    logic [CW-1:0]       rd_inc;

    scfp_crc8 u_crc (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (crc_cmd),
        .stat  (crc_stat)
    );

    scfp_ram #(
        .WIDTH (8),
        .DEPTH (MAX_PAYLOAD)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (fill_reg[AW-1:0]),
        .wdata (rx_byte),
        .raddr (rd_idx_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    assign accept    = in_valid && (state_reg == S_IDLE);
    assign slot_free = !out_valid_reg || out_ready;
    assign len_bad   = (rx_byte > 8'(MAX_PAYLOAD));
    assign is_sync   = (rx_byte == sync_reg);
    assign fill_inc  = fill_reg + 1'b1;
    assign rd_inc    = rd_idx_reg + 1'b1;
    assign ram_we    = accept && (phase_reg == PH_DATA);

    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        sync_next      = cfg_wr_en ? cfg_wr_data : sync_reg;
        len_next       = len_reg;
        fill_next      = fill_reg;
        rd_idx_next    = rd_idx_reg;
        empty_next     = empty_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && !out_ready;
        crc_cmd.start  = 1'b0;
        crc_cmd.seed   = rx_byte;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (phase_reg)
                        PH_HUNT:
                        begin
                            if (is_sync)
                            begin
                                phase_next = PH_LEN;
                            end
                        end
                        PH_LEN:
                        begin
                            if (len_bad)
                            begin
                                // bogus length that looks like sync restarts the frame
                                phase_next = is_sync ? PH_LEN : PH_HUNT;
                            end
                            else
                            begin
                                len_next      = rx_byte[CW-1:0];
                                fill_next     = '0;
                                crc_cmd.start = 1'b1;
                                crc_cmd.seed  = rx_byte;
                                phase_next    = (rx_byte == 8'h00) ? PH_CHECK : PH_DATA;
                                state_next    = S_CRC;
                            end
                        end
                        PH_DATA:
                        begin
                            fill_next     = fill_inc;
                            crc_cmd.start = 1'b1;
                            crc_cmd.seed  = crc_stat.value ^ rx_byte;
                            if (fill_inc == len_reg)
                            begin
                                phase_next = PH_CHECK;
                            end
                            state_next = S_CRC;
                        end
                        PH_CHECK:
                        begin
                            if (rx_byte == crc_stat.value)
                            begin
                                phase_next  = PH_HUNT;
                                rd_idx_next = '0;
                                if (len_reg == '0)
                                begin
                                    empty_next = 1'b1;
                                    state_next = S_OUT;
                                end
                                else
                                begin
                                    state_next = S_RD;
                                end
                            end
                            else
                            begin
                                phase_next = is_sync ? PH_LEN : PH_HUNT;
                            end
                        end
                        default:
                        begin
                            phase_next = PH_HUNT;
                        end
                    endcase
                end
            end
            S_CRC:
            begin
                if (crc_stat.last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_RD:
            begin
                // ram data for rd_idx shows up next cycle
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = empty_reg ? 8'h00 : ram_rdata;
                    rd_idx_next    = rd_inc;
                    if (empty_reg || (rd_inc == len_reg))
                    begin
                        empty_next = 1'b0;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_RD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            phase_reg     <= PH_HUNT;
            sync_reg      <= '0;
            len_reg       <= '0;
            fill_reg      <= '0;
            rd_idx_reg    <= '0;
            empty_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            sync_reg      <= sync_next;
            len_reg       <= len_next;
            fill_reg      <= fill_next;
            rd_idx_reg    <= rd_idx_next;
            empty_reg     <= empty_next;
            out_valid_reg <= out_valid_next;
            out_data_reg  <= out_data_next;
        end
    end

    assign in_ready     = (state_reg == S_IDLE);
    assign out_valid    = out_valid_reg;
    assign payload_byte = out_data_reg;

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= len_reg)
        else $error("payload fill beyond frame length");

    a_idle_crc: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !crc_stat.busy)
        else $error("ready for an item while crc still shifting");

    a_rd_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RD) |-> (rd_idx_reg < len_reg))
        else $error("read-out beyond frame length");

    a_empty_len: assert property (@(posedge clk) disable iff (!rst_n)
        empty_reg |-> (len_reg == '0) && (state_reg == S_OUT))
        else $error("empty marker on a non-empty frame");

endmodule
